FILE: sv/deq_pkg.sv
// Shared types and codes for the double-ended queue core.
package deq_pkg;

    // Request kind carried on s_tuser
    typedef enum logic [2:0] {
        KIND_PUSH_BACK  = 3'd0,
        KIND_PUSH_FRONT = 3'd1,
        KIND_POP_BACK   = 3'd2,
        KIND_POP_FRONT  = 3'd3,
        KIND_CLEAR      = 3'd4
    } deq_kind_t;

    // Result status carried on m_tuser
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } deq_status_t;

    // Field widths of the stream payloads
    localparam int KIND_W   = 3;
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;
    localparam int OUT_TDATA_W = 104;  // 32 + 5 + 32 + 32 = 101, padded to bytes

    // One-cycle command broadcast to every cell; already qualified by full/empty
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
        logic clear;
    } deq_cmd_t;

endpackage

FILE: sv/deq_cell.sv
// One storage cell of the deque row: holds one element and its occupied flag.
module deq_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  deq_pkg::deq_cmd_t     cmd,
    input  logic [DATA_WIDTH-1:0] push_data,   // element for a push at the back
    input  logic [DATA_WIDTH-1:0] left_data,   // neighbor nearer the front
    input  logic                  left_occ,
    input  logic [DATA_WIDTH-1:0] right_data,  // neighbor nearer the back
    input  logic                  right_occ,
    output logic [DATA_WIDTH-1:0] data,
    output logic                  occ
);
    import deq_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic                  occ_reg, occ_next;

    // Next state from the broadcast command and both neighbors
    always_comb begin
        occ_next  = occ_reg;
        data_next = data_reg;
        if (cmd.clear) begin
            occ_next = 1'b0;
        end else if (cmd.push_front) begin
            // whole row shifts one place toward the back
            occ_next  = left_occ;
            data_next = left_data;
        end else if (cmd.push_back) begin
            // first empty cell takes the element
            if (!occ_reg && left_occ) begin
                occ_next  = 1'b1;
                data_next = push_data;
            end
        end else if (cmd.pop_front) begin
            // whole row shifts one place toward the front
            occ_next  = right_occ;
            data_next = right_data;
        end else if (cmd.pop_back) begin
            // last occupied cell lets go of its element
            if (occ_reg && !right_occ) begin
                occ_next = 1'b0;
            end
        end
    end

    // Occupied flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    // Element payload, no reset
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign occ  = occ_reg;

endmodule

FILE: sv/double_ended_queue_core.sv
// Double-ended queue core: a row of shifting cells with front/back push and pop.
//
//  Channel | Dir | Handshake          | Payload
//  --------+-----+--------------------+-----------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser: kind[2:0]; tdata: value[31:0]
//  m_      | out | m_tvalid/m_tready  | tuser: status[1:0]; tdata: popped, occupancy,
//          |     |                    |        front, back (from bit 0 up)
//
// Each request moves from S_IDLE through S_CALC to S_OUT, where it waits out any
// output stall: the cells update on the accepting edge, S_CALC registers
// front/back from the row, then S_OUT offers the result. The front is always
// cell 0; the back is the last occupied cell, found by an AND-OR across the row.
// Synchronous active-low reset empties every cell; stored elements need no clearing.
// A stalled result holds s_tready low until m_tready takes it.
module double_ended_queue_core #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [deq_pkg::FIELD_W-1:0]       s_tdata,   // value[31:0]
    input  logic [deq_pkg::KIND_W-1:0]        s_tuser,   // kind[2:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // popped[31:0], occupancy[36:32], front[68:37], back[100:69], zero[103:101]
    output logic [deq_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [deq_pkg::STATUS_W-1:0]      m_tuser    // status[1:0]
);
    import deq_pkg::*;

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int XW  = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;
    localparam int OXW = (CW > OCC_W) ? CW : OCC_W;

    typedef enum logic [1:0] {S_IDLE, S_CALC, S_OUT} state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0]  popped_reg, popped_next;
    deq_status_t            status_reg, status_next;
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [STATUS_W-1:0]    m_tuser_reg;

    logic                   accept, full, empty;
    deq_kind_t              kind;
    deq_cmd_t               cmd;
    logic signed [FIELD_W-1:0] in_value;
    logic signed [XW-1:0]   in_wide;
    logic [DATA_WIDTH-1:0]  push_value;

    logic [DATA_WIDTH-1:0]  cell_data [DEPTH];
    logic                   cell_occ  [DEPTH];
    logic [DEPTH-1:0]       occ_bits;
    logic [DATA_WIDTH-1:0]  back_cur, front_cur;

    // Input decode
    assign accept     = s_tvalid && s_tready;
    assign kind       = deq_kind_t'(s_tuser);
    assign in_value   = s_tdata;
    assign in_wide    = XW'(in_value);
    assign push_value = in_wide[DATA_WIDTH-1:0];
    assign full       = (cnt_reg == CW'(DEPTH));
    assign empty      = (cnt_reg == '0);

    // Qualified command to the cell row
    always_comb begin
        cmd = '0;
        if (accept) begin
            case (kind)
                KIND_PUSH_BACK:  cmd.push_back  = !full;
                KIND_PUSH_FRONT: cmd.push_front = !full;
                KIND_POP_BACK:   cmd.pop_back   = !empty;
                KIND_POP_FRONT:  cmd.pop_front  = !empty;
                KIND_CLEAR:      cmd.clear      = 1'b1;
                default:         cmd = '0;
            endcase
        end
    end

    // Row of cells; cell 0 is the front
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] l_data, r_data;
        logic                  l_occ, r_occ;
        if (i == 0) begin : g_first
            assign l_data = push_value;
            assign l_occ  = 1'b1;
        end else begin : g_mid_l
            assign l_data = cell_data[i-1];
            assign l_occ  = cell_occ[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign r_data = '0;
            assign r_occ  = 1'b0;
        end else begin : g_mid_r
            assign r_data = cell_data[i+1];
            assign r_occ  = cell_occ[i+1];
        end
        deq_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .push_data  (push_value),
            .left_data  (l_data),
            .left_occ   (l_occ),
            .right_data (r_data),
            .right_occ  (r_occ),
            .data       (cell_data[i]),
            .occ        (cell_occ[i])
        );
    end

    // Front and back of the current row; zero when empty
    always_comb begin
        back_cur = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (i == DEPTH - 1) begin
                back_cur = back_cur | (cell_data[i] & {DATA_WIDTH{cell_occ[i]}});
            end else begin
                back_cur = back_cur |
                    (cell_data[i] & {DATA_WIDTH{cell_occ[i] && !cell_occ[i+1]}});
            end
        end
    end
    assign front_cur = cell_occ[0] ? cell_data[0] : '0;

    // Count, status and popped element taken at the accepting edge
    always_comb begin
        cnt_next    = cnt_reg;
        popped_next = popped_reg;
        status_next = status_reg;
        if (accept) begin
            popped_next = '0;
            status_next = STAT_OK;
            case (kind)
                KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
                    if (full) begin
                        status_next = STAT_FULL;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                KIND_POP_BACK, KIND_POP_FRONT: begin
                    if (empty) begin
                        status_next = STAT_EMPTY;
                    end else begin
                        cnt_next    = cnt_reg - 1'b1;
                        popped_next = (kind == KIND_POP_FRONT) ? cell_data[0] : back_cur;
                    end
                end
                KIND_CLEAR: begin
                    cnt_next = '0;
                end
                default: begin
                    cnt_next = cnt_reg;
                end
            endcase
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_CALC;
            S_CALC:  state_next = S_OUT;
            S_OUT:   if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Output field formatting
    logic signed [DATA_WIDTH-1:0] popped_s, front_s, back_s;
    logic signed [XW-1:0]         popped_x, front_x, back_x;
    logic [OXW-1:0]               occ_x;
    assign popped_s = popped_reg;
    assign front_s  = front_cur;
    assign back_s   = back_cur;
    assign popped_x = XW'(popped_s);
    assign front_x  = XW'(front_s);
    assign back_x   = XW'(back_s);
    assign occ_x    = OXW'(cnt_reg);

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == S_CALC) begin
                m_tvalid_reg <= 1'b1;
            end else if (state_reg == S_OUT && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result payload, no reset
    always_ff @(posedge aclk) begin
        popped_reg <= popped_next;
        status_reg <= status_next;
        if (state_reg == S_CALC) begin
            m_tdata_reg <= {3'b000, back_x[FIELD_W-1:0], front_x[FIELD_W-1:0],
                            occ_x[OCC_W-1:0], popped_x[FIELD_W-1:0]};
            m_tuser_reg <= status_reg;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Occupied flags gathered into one vector for the count check
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            occ_bits[i] = cell_occ[i];
        end
    end

    // Checks
    a_cnt_matches_row: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == CW'($countones(occ_bits)))
        else $error("element count disagrees with occupied cells");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid_reg))
        else $error("new request taken while a result is pending");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CALC && status_reg == STAT_FULL) |-> full)
        else $error("full status reported on a queue with room");

    a_empty_front: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && empty |=> !cell_occ[0] || (state_reg == S_CALC && cnt_reg != '0))
        else $error("front cell occupied while queue is empty");

endmodule

FILE: dv/deq_checker.sv
// Checker for the double-ended queue core: mirrors the ring and compares every result.
`timescale 1ns / 1ps

module deq_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [deq_pkg::FIELD_W-1:0]     s_tdata,   // value[31:0]
    input  logic [deq_pkg::KIND_W-1:0]      s_tuser,   // kind[2:0]
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // popped[31:0], occupancy[36:32], front[68:37], back[100:69], zero[103:101]
    input  logic [deq_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic [deq_pkg::STATUS_W-1:0]    m_tuser,   // status[1:0]
    output int                              mismatches,
    output int                              outstanding
);

    import deq_pkg::*;

    localparam int RING_DEPTH = 16;
    // keep the log readable when the core is badly broken
    localparam int REPORT_CAP = 100;

    typedef struct packed {
        logic [31:0] popped;
        deq_status_t status;
        logic [4:0]  occupancy;
        logic [31:0] front;
        logic [31:0] back;
    } deq_result_t;

    // Mirror of the queue contents
    logic [31:0] ring [RING_DEPTH];
    logic [3:0]  head;
    logic [4:0]  stored;

    deq_result_t due_results[$];
    deq_result_t got, want;
    int          in_step, out_step;

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    // Apply one request to the mirror and return the result it should produce
    function automatic deq_result_t apply_request(input logic [2:0] kind,
                                                  input logic [31:0] value);
        deq_result_t r;
        logic [3:0]  tail;
        r = '0;
        case (kind)
            KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
                if (stored == RING_DEPTH) begin
                    r.status = STAT_FULL;
                end else if (kind == KIND_PUSH_BACK) begin
                    tail = head + stored[3:0];
                    ring[tail] = value;
                    stored = stored + 5'd1;
                end else begin
                    head = head - 4'd1;
                    ring[head] = value;
                    stored = stored + 5'd1;
                end
            end
            KIND_POP_BACK, KIND_POP_FRONT: begin
                if (stored == 0) begin
                    r.status = STAT_EMPTY;
                end else if (kind == KIND_POP_BACK) begin
                    tail = head + stored[3:0] - 4'd1;
                    r.popped = ring[tail];
                    stored = stored - 5'd1;
                end else begin
                    r.popped = ring[head];
                    head = head + 4'd1;
                    stored = stored - 5'd1;
                end
            end
            KIND_CLEAR: begin
                stored = '0;
                head   = '0;
            end
            default: ;  // unused kinds leave the ring alone
        endcase
        r.occupancy = stored;
        // front and back only read slots that hold live elements
        if (stored != 0) begin
            tail    = head + stored[3:0] - 4'd1;
            r.front = ring[head];
            r.back  = ring[tail];
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $error("%s mismatch: expected %0d, actual %0d",
                       name, $signed(exp_val), $signed(act_val));
        end
    endtask

    // Predict on accepted requests, compare on accepted results
    always @(posedge aclk) begin
        if (!aresetn) begin
            head   = '0;
            stored = '0;
            due_results.delete();
            outstanding <= 0;
        end else begin
            in_step  = 0;
            out_step = 0;
            if (m_tvalid && m_tready) begin
                out_step = 1;
                got = {m_tdata[31:0], m_tuser, m_tdata[36:32], m_tdata[68:37],
                       m_tdata[100:69]};
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $error("result with no request pending: tdata 0x%h tuser %0d",
                               m_tdata, m_tuser);
                end else begin
                    want = due_results.pop_front();
                    check_field("popped_value", want.popped, got.popped);
                    check_field("status", want.status, got.status);
                    check_field("occupancy", want.occupancy, got.occupancy);
                    check_field("front_value", want.front, got.front);
                    check_field("back_value", want.back, got.back);
                    check_field("tdata padding", '0, m_tdata[103:101]);
                end
            end
            if (s_tvalid && s_tready) begin
                in_step = 1;
                due_results.push_back(apply_request(s_tuser, s_tdata));
            end
            outstanding <= outstanding + in_step - out_step;
        end
    end

endmodule

FILE: dv/tb_top.sv
// Top of the double-ended queue testbench: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps

module tb_top;

    import deq_pkg::*;

    localparam int RANDOM_ITEMS  = 2000;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_GAP       = 14;
    localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [FIELD_W-1:0]     s_tdata  = '0;
    logic [KIND_W-1:0]      s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]    m_tuser;

    int mismatches;
    int outstanding;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    int results_taken = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    double_ended_queue_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    deq_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Offer one request after a random gap (none in a burst) and hold it until accepted
    task automatic send_request(input logic [2:0] kind, input logic [31:0] value);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Result side: random stalls per result, two long hold-offs to back up the core
    initial begin : result_sink
        int low_cycles;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (results_taken % 64 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            low_cycles = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (results_taken == 300 || results_taken == 1200)
                low_cycles = HOLD_CYCLES;
            if (low_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (low_cycles) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            results_taken++;
        end
    end

    // Abort when neither channel moves for too long
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("double_ended_queue_core verification failed");
        $finish;
    end

    // Request stream and verdict
    initial begin : stimulus
        int          push_pct;
        int          roll;
        logic [2:0]  kind;
        logic [31:0] value;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // pops on an empty queue, value must be ignored
        send_request(KIND_POP_BACK, 32'h7FFF_FFFF);
        send_request(KIND_POP_FRONT, 32'h8000_0000);
        // extreme values at both ends
        send_request(KIND_PUSH_BACK, 32'h7FFF_FFFF);
        send_request(KIND_PUSH_FRONT, 32'h8000_0000);
        send_request(KIND_PUSH_BACK, 32'h0000_0000);
        send_request(KIND_PUSH_FRONT, 32'hFFFF_FFFF);
        // fill to capacity, then try both pushes on a full queue
        for (int i = 0; i < 12; i++)
            send_request(i[0] ? KIND_PUSH_FRONT : KIND_PUSH_BACK,
                         i[1] ? 32'h5555_5555 ^ i : 32'hAAAA_AAAA ^ i);
        send_request(KIND_PUSH_BACK, 32'h1234_5678);
        send_request(KIND_PUSH_FRONT, 32'h8765_4321);
        send_request(KIND_POP_BACK, '0);
        send_request(KIND_POP_FRONT, '0);
        // unused kinds only report the state
        for (int k = KIND_UNUSED_LO; k <= KIND_UNUSED_HI; k++)
            send_request(k[2:0], $urandom());
        send_request(KIND_CLEAR, 32'hFFFF_FFFF);

        // random traffic in phases biased toward filling, draining or neither
        push_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) begin
                tx_burst = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 2))
                    0:       push_pct = 25;
                    1:       push_pct = 50;
                    default: push_pct = 80;
                endcase
            end
            // let the core drain completely once mid-run
            if (n == RANDOM_ITEMS / 2) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (outstanding != 0) @(posedge aclk);
            end
            roll = $urandom_range(0, 99);
            if (roll < 1)
                kind = KIND_CLEAR;
            else if (roll < 3)
                kind = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
            else if (roll < 3 + push_pct * 97 / 100)
                kind = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
            else
                kind = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
            case ($urandom_range(0, 7))
                0:       value = 32'h7FFF_FFFF;
                1:       value = 32'h8000_0000;
                2:       value = 32'h0000_0000;
                3:       value = 32'hFFFF_FFFF;
                default: value = $urandom();
            endcase
            send_request(kind, value);
        end
        s_tvalid <= 1'b0;

        // wait for the last results, then let the bench settle for anything stray
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0 && outstanding == 0)
            $display("double_ended_queue_core verification clean");
        else
            $display("double_ended_queue_core verification failed");
        $finish;
    end

endmodule

FILE: files.f
sv/deq_pkg.sv
sv/deq_cell.sv
sv/double_ended_queue_core.sv
dv/deq_checker.sv
dv/tb_top.sv
